/* sv/spim_pkg.sv */
package spim_pkg;

	localparam int DATA_BITS_DEF = 8;
	localparam int APB_ADDR_W    = 5;
	localparam int APB_DATA_W    = 32;
	localparam int REG_IDX_W     = 3;
	localparam int PRESCALE_W    = 7;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_STAT  = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LSB_FIRST = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_IDLE_HIGH = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_2  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SPEED     = 3'd4;

	localparam int STAT_DONE_BIT = 7;
	localparam int STAT_COLL_BIT = 6;

	typedef struct packed {
		logic       enable;
		logic       lsb_first;
		logic       clock_idle_high;
		logic       sample_second_edge;
		logic [1:0] speed_select;
	} cfg_t;

	typedef struct packed {
		logic       mosi;
		logic       sclk;
		logic       busy_res;
		logic       collision_flag;
		logic       done_flag;
		logic [7:0] read_value;
	} result_t;

	// Ticks per clock half period for each speed setting.
	function automatic logic [PRESCALE_W-1:0] half_period(input logic [1:0] speed);
		logic [PRESCALE_W-1:0] h;
		case (speed)
			2'd0: h = 7'd2;
			2'd1: h = 7'd8;
			2'd2: h = 7'd32;
			default: h = 7'd64;
		endcase
		return h;
	endfunction

endpackage

/* sv/spi_master_controller.sv */
// Channel   Direction  tdata (low bit up)                         tuser
// s_axis    in         write_value[7:0], miso[8]                  cmd[1:0]
// m_axis    out        read_value[7:0], done_flag[8],             -
//                      collision_flag[9], busy_res[10], sclk[11],
//                      mosi[12]
// apb       in/out     register i at byte address 4*i
//
// One transaction is accepted per cycle while m_axis is not stalled.
// Each transaction passes an input register, then one pass of the engine into the
// output register, which is also where the controller state advances.
// While m_axis_tready is low the result holds and the input register takes one more.
// arst_n at once clears valid flags, engine state and config, but not data registers.
module spi_master_controller #(
	parameter int DATA_BITS = spim_pkg::DATA_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [15:0]                       s_axis_tdata,  // write_value, miso
	input  logic [1:0]                        s_axis_tuser,  // cmd
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [15:0]                       m_axis_tdata,  // read_value, done_flag,
	                                                         // collision_flag, busy_res,
	                                                         // sclk, mosi
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [spim_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [spim_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [spim_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	spim_pkg::cfg_t    cfg;
	logic              abort;
	spim_pkg::result_t eng_res;
	spim_pkg::result_t res_q;
	logic              out_vld_q;
	logic              vld_s1;
	logic [1:0]        cmd_s1;
	logic [7:0]        wv_s1;
	logic              miso_s1;
	logic              adv;

	assign adv           = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tuser;
			wv_s1   <= s_axis_tdata[7:0];
			miso_s1 <= s_axis_tdata[8];
		end
	end

	spim_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.abort   (abort)
	);

	spim_engine #(
		.DATA_BITS (DATA_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.cmd         (cmd_s1),
		.write_value (wv_s1),
		.miso        (miso_s1),
		.cfg         (cfg),
		.abort       (abort),
		.res         (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || m_axis_tready) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= eng_res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {3'b000, res_q.mosi, res_q.sclk, res_q.busy_res,
	                        res_q.collision_flag, res_q.done_flag, res_q.read_value};

	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !cfg.enable |-> !eng_res.busy_res)
		else $error("transfer running while disabled");

	a_idle_clock: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !eng_res.busy_res |-> eng_res.sclk == cfg.clock_idle_high)
		else $error("serial clock not at idle level between transfers");

	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd_s1 != spim_pkg::CMD_READ |-> eng_res.read_value == 8'd0)
		else $error("read data returned on a non-read transaction");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_axis_tvalid && m_axis_tdata[12:8] == {$past(eng_res.mosi),
			$past(eng_res.sclk), $past(eng_res.busy_res),
			$past(eng_res.collision_flag), $past(eng_res.done_flag)})
		else $error("result register lost an engine result");

endmodule

/* sv/spim_regs.sv */
module spim_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [spim_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [spim_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [spim_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output spim_pkg::cfg_t                      cfg,
	output logic                                abort
);

	spim_pkg::cfg_t                   cfg_q;
	logic                             wr;
	logic [spim_pkg::REG_IDX_W-1:0]   idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[spim_pkg::APB_ADDR_W-1:2];
	assign cfg    = cfg_q;

	// Clearing the enable bit ends any transfer in flight.
	assign abort  = wr && (idx == spim_pkg::REG_ENABLE) && !pwdata[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (idx)
				spim_pkg::REG_ENABLE:    cfg_q.enable             <= pwdata[0];
				spim_pkg::REG_LSB_FIRST: cfg_q.lsb_first          <= pwdata[0];
				spim_pkg::REG_IDLE_HIGH: cfg_q.clock_idle_high    <= pwdata[0];
				spim_pkg::REG_SAMPLE_2:  cfg_q.sample_second_edge <= pwdata[0];
				spim_pkg::REG_SPEED:     cfg_q.speed_select       <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			spim_pkg::REG_ENABLE:    prdata[0]   = cfg_q.enable;
			spim_pkg::REG_LSB_FIRST: prdata[0]   = cfg_q.lsb_first;
			spim_pkg::REG_IDLE_HIGH: prdata[0]   = cfg_q.clock_idle_high;
			spim_pkg::REG_SAMPLE_2:  prdata[0]   = cfg_q.sample_second_edge;
			spim_pkg::REG_SPEED:     prdata[1:0] = cfg_q.speed_select;
			default: ;
		endcase
	end

endmodule

/* sv/spim_engine.sv */
module spim_engine #(
	parameter int DATA_BITS = spim_pkg::DATA_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [1:0]           cmd,
	input  logic [7:0]           write_value,
	input  logic                 miso,
	input  spim_pkg::cfg_t       cfg,
	input  logic                 abort,
	output spim_pkg::result_t    res
);

	localparam int EdgeTotal = 2 * DATA_BITS;
	localparam int EdgeW     = $clog2(EdgeTotal + 1);
	localparam int PsW       = spim_pkg::PRESCALE_W;

	logic [DATA_BITS-1:0] shift_q, shift_d;
	logic [DATA_BITS-1:0] rxbuf_q, rxbuf_d;
	logic [EdgeW-1:0]     edge_q, edge_d;
	logic [PsW-1:0]       ps_q, ps_d;
	logic                 busy_q, busy_d;
	logic                 done_q, done_d;
	logic                 coll_q, coll_d;
	logic                 clk_lvl_q, clk_lvl_d;
	logic                 mosi_q, mosi_d;

	logic [DATA_BITS+7:0] wv_ext;
	logic [DATA_BITS+7:0] rx_ext;
	logic [DATA_BITS-1:0] load_word;
	logic [DATA_BITS-1:0] sampled;
	logic [PsW-1:0]       ps_inc;
	logic [EdgeW-1:0]     edge_inc;
	logic                 leading;

	assign wv_ext    = {{DATA_BITS{1'b0}}, write_value};
	assign load_word = wv_ext[DATA_BITS-1:0];
	assign ps_inc    = ps_q + PsW'(1);
	assign edge_inc  = edge_q + EdgeW'(1);
	assign leading   = edge_inc[0];
	assign sampled   = cfg.lsb_first ? {miso, shift_q[DATA_BITS-1:1]}
	                                 : {shift_q[DATA_BITS-2:0], miso};

	always_comb begin
		shift_d   = shift_q;
		rxbuf_d   = rxbuf_q;
		edge_d    = edge_q;
		ps_d      = ps_q;
		busy_d    = busy_q;
		done_d    = done_q;
		coll_d    = coll_q;
		clk_lvl_d = clk_lvl_q;
		mosi_d    = mosi_q;
		case (cmd)
			spim_pkg::CMD_TICK: begin
				if (busy_q) begin
					if (ps_inc < spim_pkg::half_period(cfg.speed_select)) begin
						ps_d = ps_inc;
					end else begin
						ps_d      = '0;
						clk_lvl_d = !clk_lvl_q;
						edge_d    = edge_inc;
						if (leading != cfg.sample_second_edge) begin
							shift_d = sampled;
						end else if (edge_inc < EdgeW'(EdgeTotal)) begin
							mosi_d = cfg.lsb_first ? shift_q[0] : shift_q[DATA_BITS-1];
						end
						if (edge_inc >= EdgeW'(EdgeTotal)) begin
							rxbuf_d   = shift_d;
							done_d    = 1'b1;
							busy_d    = 1'b0;
							clk_lvl_d = 1'b0;
							edge_d    = '0;
						end
					end
				end
			end
			spim_pkg::CMD_WRITE: begin
				if (cfg.enable) begin
					if (busy_q) begin
						coll_d = 1'b1;
					end else begin
						shift_d   = load_word;
						busy_d    = 1'b1;
						edge_d    = '0;
						ps_d      = '0;
						clk_lvl_d = 1'b0;
						if (!cfg.sample_second_edge) begin
							mosi_d = cfg.lsb_first ? load_word[0] : load_word[DATA_BITS-1];
						end
					end
				end
			end
			spim_pkg::CMD_STAT: begin
				if (write_value[spim_pkg::STAT_DONE_BIT]) begin
					done_d = 1'b0;
				end
				if (write_value[spim_pkg::STAT_COLL_BIT]) begin
					coll_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= '0;
			rxbuf_q   <= '0;
			edge_q    <= '0;
			ps_q      <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			coll_q    <= 1'b0;
			clk_lvl_q <= 1'b0;
			mosi_q    <= 1'b0;
		end else if (abort) begin
			busy_q    <= 1'b0;
			clk_lvl_q <= 1'b0;
			edge_q    <= '0;
			ps_q      <= '0;
		end else if (step) begin
			shift_q   <= shift_d;
			rxbuf_q   <= rxbuf_d;
			edge_q    <= edge_d;
			ps_q      <= ps_d;
			busy_q    <= busy_d;
			done_q    <= done_d;
			coll_q    <= coll_d;
			clk_lvl_q <= clk_lvl_d;
			mosi_q    <= mosi_d;
		end
	end

	assign rx_ext = {8'b0, rxbuf_d};

	always_comb begin
		res                = '0;
		res.read_value     = (cmd == spim_pkg::CMD_READ) ? rx_ext[7:0] : 8'd0;
		res.done_flag      = done_d;
		res.collision_flag = coll_d;
		res.busy_res       = busy_d;
		res.sclk           = clk_lvl_d ^ cfg.clock_idle_high;
		res.mosi           = mosi_d;
	end

endmodule
